// ----- hdl/retransmit_backoff_timer_unit_defines.svh -----
// Assertion macros shared by the retransmit backoff timer checkers.
`ifndef RETRANSMIT_BACKOFF_TIMER_UNIT_DEFINES_SVH
`define RETRANSMIT_BACKOFF_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rbt_pkg.sv -----
// Types and constants shared by the retransmit backoff timer modules.
package rbt_pkg;

    // Field and register widths.
    localparam int RT_W       = 21;
    localparam int IRT_W      = 17;
    localparam int MRT_W      = 20;
    localparam int MRT_K_W    = 30;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // Divide-by-1000 helpers: the dividend is first shifted down by three,
    // then divided by 125 through a reciprocal multiply and one correction.
    localparam int               DIV_Q_W   = 22;
    localparam int               DIV_SHIFT = 28;
    localparam logic [21:0]      DIV_RECIP = 22'd2147483;
    localparam logic [28:0]      DIV_BASE  = 29'd125;

    // Input item modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Result send kinds.
    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_FIRST = 2'd1;
    localparam logic [1:0] SEND_RETX  = 2'd2;

    // Reported phase codes.
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_DELAY = 2'd1;
    localparam logic [1:0] PHASE_WAIT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RT  = 1'd1;

    // Configuration reset values.
    localparam logic [IRT_W-1:0]   INIT_RT_RST  = 17'd1000;
    localparam logic [MRT_W-1:0]   MAX_RT_RST   = 20'd120000;
    localparam logic [MRT_K_W-1:0] MAX_RT_K_RST = 30'd120000000;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [7:0] jitter;
        logic [9:0]        start_delay;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      send_kind;
        logic [RT_W-1:0] rt_now;
        logic [1:0]      phase;
    } t_out_item;

    // Configuration as seen by the datapath; max_rt_k is max_rt times 1000.
    typedef struct packed {
        logic [IRT_W-1:0]   init_rt;
        logic [MRT_W-1:0]   max_rt;
        logic [MRT_K_W-1:0] max_rt_k;
    } t_cfg;

    // Request into the RT calculation unit.
    typedef struct packed {
        logic              start;
        logic              first;
        logic signed [7:0] jitter;
        logic [RT_W-1:0]   cur_rt;
    } t_calc_req;

    // Response from the RT calculation unit.
    typedef struct packed {
        logic            done;
        logic [RT_W-1:0] rt;
    } t_calc_rsp;

endpackage

// ----- hdl/rbt_cfg.sv -----
// Configuration registers of the retransmit backoff timer.
module rbt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output rbt_pkg::t_cfg                  o_cfg
);
    import rbt_pkg::*;

    logic [IRT_W-1:0]   r_init_rt;
    logic [MRT_W-1:0]   r_max_rt;
    logic [MRT_K_W-1:0] r_max_rt_k;
    logic [MRT_K_W-1:0] max_rt_k_wr;

    // Ceiling times 1000 as shifts: 1024 - 16 - 8.
    assign max_rt_k_wr = {i_cfg_wdata, 10'b0}
                       - {6'b0, i_cfg_wdata, 4'b0}
                       - {7'b0, i_cfg_wdata, 3'b0};

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_rt  <= INIT_RT_RST;
            r_max_rt   <= MAX_RT_RST;
            r_max_rt_k <= MAX_RT_K_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_RT: begin
                    r_init_rt <= i_cfg_wdata[IRT_W-1:0];
                end
                CFG_MAX_RT: begin
                    r_max_rt   <= i_cfg_wdata[MRT_W-1:0];
                    r_max_rt_k <= max_rt_k_wr;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.init_rt  = r_init_rt;
    assign o_cfg.max_rt   = r_max_rt;
    assign o_cfg.max_rt_k = r_max_rt_k;

endmodule

// ----- hdl/rbt_rt_calc.sv -----
// Four-stage unit that computes the next retransmission time with jitter.
module rbt_rt_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbt_pkg::t_cfg      i_cfg,
    input  rbt_pkg::t_calc_req i_req,
    input  logic               i_take,
    output rbt_pkg::t_calc_rsp o_rsp
);
    import rbt_pkg::*;

    logic [11:0]          f_first;
    logic [11:0]          f_retx;
    logic [RT_W-1:0]      mul_a;
    logic [11:0]          mul_b;
    logic [32:0]          p_main;
    logic [30:0]          p_clamp;
    logic                 over;
    logic [30:0]          dividend;
    logic [49:0]          p_recip;
    logic [28:0]          est125;
    logic [28:0]          rem;
    logic [DIV_Q_W-1:0]   quot;

    logic                 r1_vld;
    logic                 r1_first;
    logic [32:0]          r1_main;
    logic [30:0]          r1_clamp;
    logic                 r2_vld;
    logic [27:0]          r2_e;
    logic                 r3_vld;
    logic [27:0]          r3_e;
    logic [DIV_Q_W-1:0]   r3_est;
    logic                 r4_vld;
    logic [RT_W-1:0]      r4_rt;

    // Stage 1: jittered factors (always positive) and the two products.
    assign f_first = 12'd1000 + {{4{i_req.jitter[7]}}, i_req.jitter};
    assign f_retx  = 12'd2000 + {{4{i_req.jitter[7]}}, i_req.jitter};
    assign mul_a   = i_req.first ? {4'b0, i_cfg.init_rt} : i_req.cur_rt;
    assign mul_b   = i_req.first ? f_first : f_retx;
    assign p_main  = 33'(mul_a) * 33'(mul_b);
    assign p_clamp = 31'(i_cfg.max_rt) * 31'(f_first[10:0]);

    // Stage 2: apply the ceiling; the chosen dividend always fits 31 bits.
    assign over     = !r1_first && (r1_main > 33'(i_cfg.max_rt_k));
    assign dividend = over ? r1_clamp : r1_main[30:0];

    // Stage 3: quotient estimate by 125, low by at most one.
    assign p_recip = 50'(r2_e) * 50'(DIV_RECIP);

    // Stage 4: one correction step against the remainder.
    assign est125 = {r3_est, 7'b0} - {5'b0, r3_est, 2'b0} + {7'b0, r3_est};
    assign rem    = {1'b0, r3_e} - est125;
    assign quot   = (rem >= DIV_BASE) ? (r3_est + 22'd1) : r3_est;

    // Stage valid bits; the last stage holds until the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_req.start;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            if (r3_vld) begin
                r4_vld <= 1'b1;
            end else if (i_take) begin
                r4_vld <= 1'b0;
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r1_first <= i_req.first;
            r1_main  <= p_main;
            r1_clamp <= p_clamp;
        end
        if (r1_vld) begin
            r2_e <= dividend[30:3];
        end
        if (r2_vld) begin
            r3_e   <= r2_e;
            r3_est <= p_recip[DIV_SHIFT +: DIV_Q_W];
        end
        if (r3_vld) begin
            r4_rt <= quot[RT_W-1:0];
        end
    end

    assign o_rsp.done = r4_vld;
    assign o_rsp.rt   = r4_rt;

endmodule

// ----- hdl/retransmit_backoff_timer_unit.sv -----
// Top level of the retransmit backoff timer: input stage, timer state, result register.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_ready /
// i_in_item) and each one produces exactly one result on the output
// channel (o_out_valid / i_out_ready / o_out_item). Start loads the start
// delay, a tick counts one millisecond, stop returns the timer to idle.
// The user must write the two registers through i_cfg_we / i_cfg_idx /
// i_cfg_wdata only while no item is in flight; the block does not enforce it.
// Flow: a result is registered in the result register once its item in the
// input stage finishes. A tick that expires the timer first goes through
// the four-stage RT unit (jitter multiply, ceiling compare, reciprocal
// multiply by 1/125, remainder correction) before its result is registered.
// Throughput: one item per cycle while the result register is free; an
// expiring tick holds the input stage until the RT unit returns its result.
// Reset: timer idle, count and RT zero, registers at their defaults
// (initial RT 1000 ms, ceiling 120000 ms), both channels empty.
// Stall: the result register holds while i_out_ready is low; the input
// stage keeps one more item, then o_in_ready drops.
module retransmit_backoff_timer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rbt_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rbt_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import rbt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DELAY = 3'b010,
        PH_WAIT  = 3'b100
    } t_phase;

    t_cfg            cfg;
    t_calc_req       calc_req;
    t_calc_rsp       calc_rsp;

    logic            r_in_vld;
    t_in_item        r_in;
    logic            r_out_vld;
    t_out_item       r_out;
    t_phase          r_phase;
    t_phase          n_phase;
    logic [RT_W-1:0] r_remaining;
    logic [RT_W-1:0] n_remaining;
    logic [RT_W-1:0] r_cur_rt;
    logic [RT_W-1:0] n_cur_rt;
    logic            r_busy;
    logic [1:0]      n_send;
    logic [1:0]      n_phase_code;

    logic            running;
    logic            expire;
    logic            out_free;
    logic            fin;

    rbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rbt_rt_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (calc_req),
        .i_take  (fin && expire),
        .o_rsp   (calc_rsp)
    );

    // A tick expires the timer when one millisecond or less is left.
    assign running  = (r_phase != PH_IDLE);
    assign expire   = (r_in.mode == MODE_TICK) && running && (r_remaining[RT_W-1:1] == '0);
    assign out_free = !r_out_vld || i_out_ready;
    assign fin      = r_in_vld && out_free && (!expire || calc_rsp.done);

    assign o_in_ready = !r_in_vld || fin;

    // Launch the RT unit once per expiring tick.
    assign calc_req.start  = r_in_vld && expire && !r_busy;
    assign calc_req.first  = (r_phase == PH_DELAY);
    assign calc_req.jitter = r_in.jitter;
    assign calc_req.cur_rt = r_cur_rt;

    // Next timer state for the item in the input stage.
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_cur_rt    = r_cur_rt;
        n_send      = SEND_NONE;
        case (r_in.mode)
            MODE_START: begin
                n_phase     = PH_DELAY;
                n_remaining = RT_W'(r_in.start_delay);
                n_cur_rt    = '0;
            end
            MODE_TICK: begin
                if (running) begin
                    if (!expire) begin
                        n_remaining = r_remaining - 1'b1;
                    end else begin
                        n_cur_rt    = calc_rsp.rt;
                        n_remaining = calc_rsp.rt;
                        n_phase     = PH_WAIT;
                        n_send      = (r_phase == PH_DELAY) ? SEND_FIRST : SEND_RETX;
                    end
                end
            end
            MODE_STOP: begin
                n_phase     = PH_IDLE;
                n_remaining = '0;
            end
            default: begin
            end
        endcase
    end

    // Reported phase code.
    always_comb begin
        unique case (n_phase)
            PH_IDLE:  n_phase_code = PHASE_IDLE;
            PH_DELAY: n_phase_code = PHASE_DELAY;
            PH_WAIT:  n_phase_code = PHASE_WAIT;
            default:  n_phase_code = PHASE_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_busy      <= 1'b0;
            r_phase     <= PH_IDLE;
            r_remaining <= '0;
            r_cur_rt    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (fin) begin
                r_in_vld <= 1'b0;
            end
            if (fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (calc_req.start) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end
            if (fin) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_cur_rt    <= n_cur_rt;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (fin) begin
            r_out.send_kind <= n_send;
            r_out.rt_now    <= n_cur_rt;
            r_out.phase     <= n_phase_code;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ----- hdl/rbt_checker.sv -----
// Port-level checks for the retransmit backoff timer, bound to the top level.
`include "retransmit_backoff_timer_unit_defines.svh"

module rbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input rbt_pkg::t_out_item             o_out_item
);
    import rbt_pkg::*;

    // A stalled result stays put until its transfer.
    `RBT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
                    o_out_valid && !i_out_ready,
                    o_out_valid && $stable(o_out_item),
                    "result changed while stalled")

    // Any send leaves the timer waiting for a reply.
    `RBT_ASSERT_IMP(a_send_wait, i_clk, i_rst_n,
                    o_out_valid && (o_out_item.send_kind != SEND_NONE),
                    o_out_item.phase == PHASE_WAIT,
                    "send outside wait phase")

    // During the start delay nothing is sent and RT is still cleared.
    `RBT_ASSERT_IMP(a_delay_rt, i_clk, i_rst_n,
                    o_out_valid && (o_out_item.phase == PHASE_DELAY),
                    (o_out_item.send_kind == SEND_NONE) && (o_out_item.rt_now == '0),
                    "delay phase with send or nonzero RT")

    // An idle timer never sends.
    `RBT_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n,
                    o_out_valid && (o_out_item.phase == PHASE_IDLE),
                    o_out_item.send_kind == SEND_NONE,
                    "send while idle")

endmodule

bind retransmit_backoff_timer_unit rbt_checker u_rbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
